@@ hw/rtl/lef_pkg.sv @@
// ----------------------------------------------------------------------------
// lef_pkg
// Shared types and fixed constants of the local entropy filter.
// ----------------------------------------------------------------------------
package lef_pkg;

  localparam int CFG_W   = 11;  // configuration register width
  localparam int PIX_W   = 8;   // gray value width
  localparam int BINS    = 256; // histogram bins
  localparam int BIN_W   = 8;
  localparam int TERM_W  = 16;  // -p*log2(p), Q0.16
  localparam int ENT_W   = 19;  // entropy, Q3.16
  localparam int POS_W   = 10;  // output position fields
  localparam int OUT_W   = 40;  // m_tdata, padded to whole bytes

  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_CELL_RD,
    S_HIST_RD,
    S_HIST_WR,
    S_SUM_RD,
    S_SUM_ACC,
    S_OUT
  } state_t;

endpackage

@@ hw/rtl/local_entropy_filter.sv @@
// ----------------------------------------------------------------------------
// local_entropy_filter
// Shannon entropy of the gray values in a square window around each pixel,
// with replicated borders, streamed in raster order.
// ----------------------------------------------------------------------------
//  channel  | direction | beat contents
//  s_*      | in        | tuser: op, tdata: pixel
//  m_*      | out       | tdata: entropy_value, out_column, out_row; tlast: frame_done
//  cfg_*    | in        | register index and write data, one write per cycle
//
// an item that yields no result passes S_IDLE and S_CHECK only; one that yields
// a result then walks each window cell through S_CELL_RD, S_HIST_RD and S_HIST_WR
// on the single histogram ram, sweeps the bins in S_SUM_RD and S_SUM_ACC (sum and
// clear), and ends in S_OUT. after reset a clearing pass of the histogram runs first.
// a new beat is taken while a result still waits at the output; the next
// result waits in S_OUT until the output register is free.
// ----------------------------------------------------------------------------
module local_entropy_filter #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int WINDOW     = 9
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [lef_pkg::PIX_W-1:0]  s_tdata,   // pixel
  input  logic                       s_tuser,   // op
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [lef_pkg::OUT_W-1:0]  m_tdata,   // entropy_value, out_column, out_row, pad
  output logic                       m_tlast,   // frame_done
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [lef_pkg::CFG_W-1:0]  cfg_data
);

  localparam int HALF  = (WINDOW - 1) / 2;
  localparam int SIDE  = 2 * HALF + 1;
  localparam int CELLS = SIDE * SIDE;
  localparam int RING  = 2 * HALF + 2;
  localparam int COLW  = $clog2(MAX_WIDTH);
  localparam int ROWW  = $clog2(MAX_HEIGHT);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int RW    = $clog2(RING);
  localparam int DW    = $clog2(SIDE);
  localparam int CW    = $clog2(CELLS + 1);
  localparam int TBL_N = 1 << CW;
  localparam int AW    = $clog2(RING * MAX_WIDTH);
  localparam longint unsigned DEN = longint'(CELLS) << 30;

  function automatic longint unsigned log2_q30(longint unsigned n);
    longint unsigned k;
    longint unsigned y;
    longint unsigned frac;
    k = 0;
    frac = 0;
    while (k < 31 && (n >> (k + 1)) != 0) k++;
    y = (n << 30) >> k;
    for (int i = 29; i >= 0; i--) begin
      y = (y * y) >> 30;
      if (y >= (64'd2 << 30)) begin
        y = y >> 1;
        frac = frac | (64'd1 << i);
      end
    end
    return (k << 30) | frac;
  endfunction

  function automatic logic [lef_pkg::TERM_W-1:0] term_of(int c);
    longint unsigned ln;
    longint unsigned num;
    ln = log2_q30(longint'(CELLS));
    if (c == 0) return '0;
    num = longint'(c) * (ln - log2_q30(longint'(c))) * 64'd65536;
    return lef_pkg::TERM_W'((num + DEN / 2) / DEN);
  endfunction

  logic [lef_pkg::TERM_W-1:0] term_tbl [TBL_N];
  for (genvar g = 0; g < TBL_N; g++) begin : g_term
    assign term_tbl[g] = term_of((g > CELLS) ? CELLS : g);
  end

  lef_pkg::state_t state, state_next;

  logic [lef_pkg::CFG_W-1:0] image_width, image_height;
  logic [WW-1:0] w_eff, wm1;
  logic [HW-1:0] h_eff, hm1;

  logic [COLW-1:0] in_col, out_col;
  logic [ROWW-1:0] in_row, out_row;
  logic [RW-1:0]   in_ring, out_ring;
  logic            input_full;

  logic [DW-1:0]      dx, dy;
  logic [ROWW:0]      row_t;
  logic [RW-1:0]      ring;
  logic [COLW:0]      col_u;
  logic [lef_pkg::BIN_W-1:0] bin_cnt;
  logic [lef_pkg::ENT_W-1:0] acc;

  // ram ports
  logic                      rs_we;
  logic [AW-1:0]             rs_waddr, rs_raddr;
  logic [lef_pkg::PIX_W-1:0] rs_rdata;
  logic                      hist_we;
  logic [lef_pkg::BIN_W-1:0] hist_waddr, hist_raddr;
  logic [CW-1:0]             hist_wdata, hist_rdata;
  logic [lef_pkg::BIN_W-1:0] bin_reg;

  logic accept, pix_write, ready, done, load_out;
  logic [COLW-1:0] wr_col, rd_col;
  logic [ROWW:0]   nr;
  logic [COLW:0]   nc;
  logic [RW:0]     start_ring;
  logic [ROWW:0]   row_tn;
  logic            row_inc;

  assign w_eff = (image_width == '0) ? WW'(1)
               : ((32'(image_width) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(image_width));
  assign h_eff = (image_height == '0) ? HW'(1)
               : ((32'(image_height) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(image_height));
  assign wm1 = w_eff - WW'(1);
  assign hm1 = h_eff - HW'(1);

  assign accept    = s_tvalid && s_tready;
  assign pix_write = accept && (s_tuser == lef_pkg::OP_PIXEL) && !input_full;
  assign wr_col    = (WW'(in_col) < wm1) ? in_col : COLW'(wm1);

  // readiness: the lower-right cell of the window has been received
  always_comb begin
    nr = (ROWW + 1)'(out_row) + (ROWW + 1)'(HALF);
    if (nr > (ROWW + 1)'(hm1)) nr = (ROWW + 1)'(hm1);
    nc = (COLW + 1)'(out_col) + (COLW + 1)'(HALF);
    if (nc > (COLW + 1)'(wm1)) nc = (COLW + 1)'(wm1);
    ready = input_full || (nr < (ROWW + 1)'(in_row))
         || (nr == (ROWW + 1)'(in_row) && nc < (COLW + 1)'(in_col));
  end

  assign done = (HW'(out_row) >= hm1) && (WW'(out_col) >= wm1);

  // first window row in the ring
  always_comb begin
    if (32'(out_row) < HALF) begin
      start_ring = '0;
    end else if (32'(out_ring) >= HALF) begin
      start_ring = (RW + 1)'(out_ring) - (RW + 1)'(HALF);
    end else begin
      start_ring = (RW + 1)'(out_ring) + (RW + 1)'(RING - HALF);
    end
  end

  assign row_tn  = row_t + (ROWW + 1)'(1);
  assign row_inc = (row_tn > (ROWW + 1)'(HALF))
                && (row_tn <= (ROWW + 1)'(hm1) + (ROWW + 1)'(HALF));

  // replicated column of the current cell
  always_comb begin
    if (col_u < (COLW + 1)'(HALF)) begin
      rd_col = '0;
    end else if (col_u - (COLW + 1)'(HALF) > (COLW + 1)'(wm1)) begin
      rd_col = COLW'(wm1);
    end else begin
      rd_col = COLW'(col_u - (COLW + 1)'(HALF));
    end
  end

  assign rs_waddr = AW'(in_ring) * AW'(MAX_WIDTH) + AW'(wr_col);
  assign rs_raddr = AW'(ring) * AW'(MAX_WIDTH) + AW'(rd_col);
  assign rs_we    = pix_write;

  lef_ram #(.WIDTH(lef_pkg::PIX_W), .DEPTH(RING * MAX_WIDTH)) u_row_store (
    .clk   (clk),
    .we    (rs_we),
    .waddr (rs_waddr),
    .wdata (s_tdata),
    .raddr (rs_raddr),
    .rdata (rs_rdata)
  );

  lef_ram #(.WIDTH(CW), .DEPTH(lef_pkg::BINS)) u_hist (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      lef_pkg::S_CLEAR:   if (bin_cnt == '1) state_next = lef_pkg::S_IDLE;
      lef_pkg::S_IDLE:    if (accept) state_next = lef_pkg::S_CHECK;
      lef_pkg::S_CHECK:   state_next = ready ? lef_pkg::S_CELL_RD : lef_pkg::S_IDLE;
      lef_pkg::S_CELL_RD: state_next = lef_pkg::S_HIST_RD;
      lef_pkg::S_HIST_RD: state_next = lef_pkg::S_HIST_WR;
      lef_pkg::S_HIST_WR: begin
        if (32'(dx) == SIDE - 1 && 32'(dy) == SIDE - 1) state_next = lef_pkg::S_SUM_RD;
        else state_next = lef_pkg::S_CELL_RD;
      end
      lef_pkg::S_SUM_RD:  state_next = lef_pkg::S_SUM_ACC;
      lef_pkg::S_SUM_ACC: state_next = (bin_cnt == '1) ? lef_pkg::S_OUT : lef_pkg::S_SUM_RD;
      lef_pkg::S_OUT:     if (!m_tvalid || m_tready) state_next = lef_pkg::S_IDLE;
      default:            state_next = lef_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_tready   = 1'b0;
    hist_we    = 1'b0;
    hist_waddr = bin_cnt;
    hist_wdata = '0;
    hist_raddr = bin_cnt;
    load_out   = 1'b0;
    case (state)
      lef_pkg::S_CLEAR:   hist_we = 1'b1;
      lef_pkg::S_IDLE:    s_tready = 1'b1;
      lef_pkg::S_HIST_RD: hist_raddr = rs_rdata;
      lef_pkg::S_HIST_WR: begin
        hist_we    = 1'b1;
        hist_waddr = bin_reg;
        hist_wdata = hist_rdata + CW'(1);
      end
      lef_pkg::S_SUM_ACC: hist_we = 1'b1;
      lef_pkg::S_OUT:     load_out = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= lef_pkg::S_CLEAR;
      image_width  <= lef_pkg::CFG_W'(320);
      image_height <= lef_pkg::CFG_W'(240);
      in_col       <= '0;
      in_row       <= '0;
      in_ring      <= '0;
      out_col      <= '0;
      out_row      <= '0;
      out_ring     <= '0;
      input_full   <= 1'b0;
      bin_cnt      <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      state <= state_next;

      if (state == lef_pkg::S_CLEAR || state == lef_pkg::S_SUM_ACC) begin
        bin_cnt <= bin_cnt + lef_pkg::BIN_W'(1);
      end

      if (cfg_we) begin
        if (cfg_index == lef_pkg::REG_IMAGE_WIDTH) image_width <= cfg_data;
        else image_height <= cfg_data;
        in_col     <= '0;
        in_row     <= '0;
        in_ring    <= '0;
        out_col    <= '0;
        out_row    <= '0;
        out_ring   <= '0;
        input_full <= 1'b0;
      end else begin
        if (pix_write) begin
          if (WW'(in_col) >= wm1) begin
            in_col <= '0;
            if (HW'(in_row) >= hm1) begin
              in_row     <= '0;
              in_ring    <= '0;
              input_full <= 1'b1;
            end else begin
              in_row  <= in_row + ROWW'(1);
              in_ring <= (32'(in_ring) == RING - 1) ? '0 : in_ring + RW'(1);
            end
          end else begin
            in_col <= in_col + COLW'(1);
          end
        end

        if (load_out) begin
          if (done) begin
            in_col     <= '0;
            in_row     <= '0;
            in_ring    <= '0;
            out_col    <= '0;
            out_row    <= '0;
            out_ring   <= '0;
            input_full <= 1'b0;
          end else if (WW'(out_col) >= wm1) begin
            out_col  <= '0;
            out_row  <= out_row + ROWW'(1);
            out_ring <= (32'(out_ring) == RING - 1) ? '0 : out_ring + RW'(1);
          end else begin
            out_col <= out_col + COLW'(1);
          end
        end
      end

      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // window walk and accumulator
  always_ff @(posedge clk) begin
    case (state)
      lef_pkg::S_CHECK: begin
        dx    <= '0;
        dy    <= '0;
        row_t <= (ROWW + 1)'(out_row);
        ring  <= RW'(start_ring);
        col_u <= (COLW + 1)'(out_col);
        acc   <= '0;
      end
      lef_pkg::S_HIST_RD: bin_reg <= rs_rdata;
      lef_pkg::S_HIST_WR: begin
        if (32'(dx) == SIDE - 1) begin
          dx    <= '0;
          dy    <= dy + DW'(1);
          col_u <= (COLW + 1)'(out_col);
          row_t <= row_tn;
          if (row_inc) ring <= (32'(ring) == RING - 1) ? '0 : ring + RW'(1);
        end else begin
          dx    <= dx + DW'(1);
          col_u <= col_u + (COLW + 1)'(1);
        end
      end
      lef_pkg::S_SUM_ACC: acc <= acc + lef_pkg::ENT_W'(term_tbl[hist_rdata]);
      default: ;
    endcase
    if (load_out) begin
      m_tdata <= {1'b0, lef_pkg::POS_W'(out_row), lef_pkg::POS_W'(out_col), acc};
      m_tlast <= done;
    end
  end

  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    state == lef_pkg::S_CLEAR |-> !s_tready)
    else $error("beat taken during histogram clearing pass");

  a_full_counters: assert property (@(posedge clk) disable iff (rst)
    input_full |-> (in_col == '0 && in_row == '0))
    else $error("input counters not parked after frame end");

  a_store_idle: assert property (@(posedge clk) disable iff (rst)
    rs_we |-> state == lef_pkg::S_IDLE)
    else $error("row store written while a window is in work");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == lef_pkg::S_OUT && !m_tvalid) |=> m_tvalid)
    else $error("finished result not presented");

endmodule

@@ hw/rtl/lef_ram.sv @@
// ----------------------------------------------------------------------------
// lef_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lef_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
